// ===== hdl/text_terminal_scroll_buffer_core_defines.svh =====
// Assertion macros shared by the terminal scroll buffer RTL.
// Depends on nothing; the using module must provide clk and arst_n.
`ifndef TEXT_TERMINAL_SCROLL_BUFFER_CORE_DEFINES_SVH
`define TEXT_TERMINAL_SCROLL_BUFFER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TTSB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define TTSB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ttsb_pkg.sv =====
// Package for the text terminal scroll buffer: geometry, widths, codes and helpers.
// Used by text_terminal_scroll_buffer_core; depends on nothing.
package ttsb_pkg;

	// Screen geometry and the widths that follow from it.
	localparam int ROWS   = 16;
	localparam int COLS   = 32;
	localparam int ROW_W  = $clog2(ROWS);
	localparam int COL_W  = $clog2(COLS);
	localparam int CELLS  = ROWS * COLS;
	localparam int ADDR_W = $clog2(CELLS);

	// Word field widths.
	localparam int KIND_W   = 2;
	localparam int BYTE_W   = 8;
	localparam int CHAR_W   = 7;
	localparam int RROW_W   = 4;
	localparam int RCOL_W   = 5;

	// Received byte codes.
	localparam logic [BYTE_W-1:0] CHAR_CR    = 8'd13;
	localparam logic [BYTE_W-1:0] CHAR_LF    = 8'd10;
	localparam logic [BYTE_W-1:0] PRINT_LO   = 8'd32;
	localparam logic [BYTE_W-1:0] PRINT_HI   = 8'd126;

	// Operation of one input word.
	typedef enum logic [KIND_W-1:0] {
		KIND_BYTE  = 2'd0,
		KIND_READ  = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	// Physical line shown at a given screen row, with the rotating top pointer.
	function automatic logic [ROW_W-1:0] phys_line(input logic [ROW_W-1:0] top,
			input logic [ROW_W-1:0] row);
		logic [ROW_W:0] sum;
		sum = {1'b0, top} + {1'b0, row};
		if (sum >= (ROW_W+1)'(ROWS)) begin
			sum = sum - (ROW_W+1)'(ROWS);
		end
		return sum[ROW_W-1:0];
	endfunction

endpackage

// ===== hdl/text_terminal_scroll_buffer_core.sv =====
// An accepted word passes from the input register to the result register.
// Throughput: one word per cycle unless the output stalls; the single read and write
// port of the cell store and the per-line length registers are each used once per word.
// Reset (arst_n, asynchronous) clears the cursor, top pointer, line lengths and
// handshake state at once; the cell store is not cleared and needs no sweep.
// Top level of the terminal scroll buffer; depends on ttsb_pkg and the defines header.
`include "text_terminal_scroll_buffer_core_defines.svh"

module text_terminal_scroll_buffer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ttsb_pkg::KIND_W-1:0]   kind,
	input  logic [ttsb_pkg::BYTE_W-1:0]   char_in,
	input  logic [ttsb_pkg::RROW_W-1:0]   read_row,
	input  logic [ttsb_pkg::RCOL_W-1:0]   read_col,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [ttsb_pkg::CHAR_W-1:0]   read_char,
	output logic [ttsb_pkg::RROW_W-1:0]   cursor_row,
	output logic [ttsb_pkg::RCOL_W-1:0]   cursor_col
);

	// Input register.
	logic                          s1_valid_q;
	ttsb_pkg::kind_t               kind_s1;
	logic [ttsb_pkg::BYTE_W-1:0]   char_s1;
	logic [ttsb_pkg::RROW_W-1:0]   row_s1;
	logic [ttsb_pkg::RCOL_W-1:0]   col_s1;

	// Terminal state.
	logic [ttsb_pkg::ROW_W-1:0]    top_q;
	logic [ttsb_pkg::ROW_W-1:0]    line_q;
	logic [ttsb_pkg::COL_W-1:0]    col_q;
	logic [ttsb_pkg::COL_W-1:0]    len_q [ttsb_pkg::ROWS];

	// Cell store.
	logic [ttsb_pkg::CHAR_W-1:0]   mem [ttsb_pkg::CELLS];
	logic [ttsb_pkg::CHAR_W-1:0]   mem_rdata_q;

	// Result register.
	logic                          out_valid_q;
	logic                          hit_q;
	logic [ttsb_pkg::RROW_W-1:0]   cursor_row_q;
	logic [ttsb_pkg::RCOL_W-1:0]   cursor_col_q;

	// Handshake and next-state signals.
	logic                          res_free;
	logic                          adv;
	logic                          in_take;
	logic [ttsb_pkg::ROW_W-1:0]    top_d;
	logic [ttsb_pkg::ROW_W-1:0]    line_d;
	logic [ttsb_pkg::COL_W-1:0]    col_d;
	logic [ttsb_pkg::ROW_W-1:0]    lf_top;
	logic [ttsb_pkg::ROW_W-1:0]    lf_line;
	logic [ttsb_pkg::ROW_W-1:0]    lf_phys;
	logic [ttsb_pkg::ROW_W-1:0]    cur_phys;
	logic [ttsb_pkg::ROW_W-1:0]    wr_phys;
	logic [ttsb_pkg::COL_W-1:0]    wr_col;
	logic                          printable;
	logic                          wrap;
	logic                          len_clr_all;
	logic                          len_we;
	logic [ttsb_pkg::ROW_W-1:0]    len_widx;
	logic [ttsb_pkg::COL_W-1:0]    len_wdata;
	logic                          mem_we;
	logic [ttsb_pkg::ADDR_W-1:0]   mem_waddr;
	logic [ttsb_pkg::ADDR_W-1:0]   mem_raddr;
	logic [ttsb_pkg::ROW_W-1:0]    rd_phys;
	logic                          rd_hit;

	// The stage advances when the result register is empty or being emptied.
	assign res_free = !out_valid_q || !out_stall;
	assign adv      = s1_valid_q && res_free;
	assign in_stall = s1_valid_q && !res_free;
	assign in_take  = in_valid && !in_stall;

	// Line feed targets, shared by explicit line feeds and by wrapping.
	always_comb begin
		if (line_q == ttsb_pkg::ROW_W'(ttsb_pkg::ROWS - 1)) begin
			lf_line = line_q;
			if (top_q == ttsb_pkg::ROW_W'(ttsb_pkg::ROWS - 1)) begin
				lf_top = '0;
			end else begin
				lf_top = top_q + ttsb_pkg::ROW_W'(1);
			end
		end else begin
			lf_line = line_q + ttsb_pkg::ROW_W'(1);
			lf_top  = top_q;
		end
		lf_phys  = ttsb_pkg::phys_line(lf_top, lf_line);
		cur_phys = ttsb_pkg::phys_line(top_q, line_q);
	end

	assign printable = (char_s1 >= ttsb_pkg::PRINT_LO) && (char_s1 <= ttsb_pkg::PRINT_HI);
	assign wrap      = 32'(col_q) >= (ttsb_pkg::COLS - 1);
	assign wr_phys   = wrap ? lf_phys : cur_phys;
	assign wr_col    = wrap ? '0 : col_q;

	// Next cursor, line length and cell writes for the word in the input register.
	always_comb begin
		top_d       = top_q;
		line_d      = line_q;
		col_d       = col_q;
		len_clr_all = 1'b0;
		len_we      = 1'b0;
		len_widx    = lf_phys;
		len_wdata   = '0;
		mem_we      = 1'b0;
		mem_waddr   = ttsb_pkg::ADDR_W'(wr_phys) * ttsb_pkg::ADDR_W'(ttsb_pkg::COLS)
			+ ttsb_pkg::ADDR_W'(wr_col);
		case (kind_s1)
			ttsb_pkg::KIND_BYTE: begin
				if (char_s1 == ttsb_pkg::CHAR_CR) begin
					col_d = '0;
				end else if (char_s1 == ttsb_pkg::CHAR_LF) begin
					top_d  = lf_top;
					line_d = lf_line;
					col_d  = '0;
					len_we = 1'b1;
				end else if (printable) begin
					if (wrap) begin
						top_d  = lf_top;
						line_d = lf_line;
					end
					col_d     = wr_col + ttsb_pkg::COL_W'(1);
					mem_we    = 1'b1;
					len_we    = 1'b1;
					len_widx  = wr_phys;
					len_wdata = wr_col + ttsb_pkg::COL_W'(1);
				end
			end
			ttsb_pkg::KIND_CLEAR: begin
				top_d       = '0;
				line_d      = '0;
				col_d       = '0;
				len_clr_all = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Read lookup: the cell counts only below its line's visible length.
	always_comb begin
		rd_phys   = ttsb_pkg::phys_line(top_q, ttsb_pkg::ROW_W'(row_s1));
		mem_raddr = ttsb_pkg::ADDR_W'(rd_phys) * ttsb_pkg::ADDR_W'(ttsb_pkg::COLS)
			+ ttsb_pkg::ADDR_W'(col_s1);
		rd_hit    = (kind_s1 == ttsb_pkg::KIND_READ)
			&& (32'(row_s1) < ttsb_pkg::ROWS)
			&& (32'(col_s1) < ttsb_pkg::COLS)
			&& (32'(col_s1) < 32'(len_q[rd_phys]));
	end

	// Input register: control with reset, payload without.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_take) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1 <= ttsb_pkg::kind_t'(kind);
			char_s1 <= char_in;
			row_s1  <= read_row;
			col_s1  <= read_col;
		end
	end

	// Cursor, top pointer and line lengths.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q  <= '0;
			line_q <= '0;
			col_q  <= '0;
			for (int i = 0; i < ttsb_pkg::ROWS; i++) begin
				len_q[i] <= '0;
			end
		end else if (adv) begin
			top_q  <= top_d;
			line_q <= line_d;
			col_q  <= col_d;
			if (len_clr_all) begin
				for (int i = 0; i < ttsb_pkg::ROWS; i++) begin
					len_q[i] <= '0;
				end
			end else if (len_we) begin
				len_q[len_widx] <= len_wdata;
			end
		end
	end

	// Cell store: at most one write and one registered read per word.
	always_ff @(posedge clk) begin
		if (adv && mem_we) begin
			mem[mem_waddr] <= char_s1[ttsb_pkg::CHAR_W-1:0];
		end
		if (adv) begin
			mem_rdata_q <= mem[mem_raddr];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hit_q        <= rd_hit;
			cursor_row_q <= ttsb_pkg::RROW_W'(line_d);
			cursor_col_q <= ttsb_pkg::RCOL_W'(col_d);
		end
	end

	assign out_valid  = out_valid_q;
	assign read_char  = hit_q ? mem_rdata_q : '0;
	assign cursor_row = cursor_row_q;
	assign cursor_col = cursor_col_q;

	// Checks on the cursor, the top pointer and the result stage.
	`TTSB_ASSERT_NEXT(a_adv_gives_result, adv, out_valid_q,
		"advanced word did not reach the result register")
	`TTSB_ASSERT_NEXT(a_clear_homes, adv && (kind_s1 == ttsb_pkg::KIND_CLEAR),
		(cursor_row == '0) && (cursor_col == '0) && (read_char == '0),
		"clear did not home the cursor")
	`TTSB_ASSERT_NEXT(a_nonread_zero, adv && (kind_s1 != ttsb_pkg::KIND_READ),
		read_char == '0, "non-read word returned a character")
	`TTSB_ASSERT_NOW(a_top_moves_at_bottom, !$stable(top_q),
		(top_q == '0) || (line_q == ttsb_pkg::ROW_W'(ttsb_pkg::ROWS - 1)),
		"top pointer moved away from the bottom row")
	`TTSB_ASSERT_NOW(a_col_in_range, s1_valid_q,
		32'(col_q) <= (ttsb_pkg::COLS - 1), "cursor column beyond the last cell")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the text terminal scroll buffer core.
// Depends on ttsb_pkg and text_terminal_scroll_buffer_core; it keeps its own
// model of the screen and compares every result word with it.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ttsb_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 7;
	localparam int DRAIN_CYCLES = 10;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int IDLE_PCT     = 6;
	localparam int HOLD_CYCLES  = 120;

	// Expected contents of one result word.
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic [RROW_W-1:0] row;
		logic [RCOL_W-1:0] col;
	} screen_answer_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [KIND_W-1:0]   kind;
	logic [BYTE_W-1:0]   char_in;
	logic [RROW_W-1:0]   read_row;
	logic [RCOL_W-1:0]   read_col;
	logic                out_valid;
	logic                out_stall;
	logic [CHAR_W-1:0]   read_char;
	logic [RROW_W-1:0]   cursor_row;
	logic [RCOL_W-1:0]   cursor_col;

	// Model of the screen: line lengths, cells, top pointer and cursor.
	int                  term_len [ROWS];
	logic [CHAR_W-1:0]   term_cell [CELLS];
	int                  term_top;
	int                  term_row;
	int                  term_col;

	screen_answer_t      due_answers [$];
	int                  errors = 0;
	int                  words_sent = 0;
	int                  answers_checked = 0;
	int                  chars_read = 0;
	int                  scrolls = 0;
	int                  cycles = 0;
	int                  hold_left = 0;
	bit                  tx_jitter = 1'b1;
	bit                  rx_jitter = 1'b1;

	text_terminal_scroll_buffer_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.char_in    (char_in),
		.read_row   (read_row),
		.read_col   (read_col),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_char  (read_char),
		.cursor_row (cursor_row),
		.cursor_col (cursor_col)
	);

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	// Physical line that the given screen row shows.
	function automatic int phys_of(input int screen_row);
		return (term_top + screen_row) % ROWS;
	endfunction

	function automatic int visible_len(input int screen_row);
		return term_len[phys_of(screen_row)];
	endfunction

	// Move to the next line, scrolling at the bottom, and empty that line.
	function automatic void feed_line();
		if (term_row + 1 >= ROWS) begin
			term_top = (term_top + 1) % ROWS;
			term_row = ROWS - 1;
			scrolls++;
		end else begin
			term_row++;
		end
		term_col = 0;
		term_len[phys_of(term_row)] = 0;
	endfunction

	function automatic void wipe_screen();
		foreach (term_len[i]) begin
			term_len[i] = 0;
		end
		term_top = 0;
		term_row = 0;
		term_col = 0;
	endfunction

	// Applies one word to the screen model and gives the answer it causes.
	function automatic screen_answer_t emulate_terminal(input kind_t op,
			input logic [BYTE_W-1:0] ch, input logic [RROW_W-1:0] row,
			input logic [RCOL_W-1:0] col);
		screen_answer_t ans;
		int             p;
		ans = '0;
		case (op)
			KIND_BYTE: begin
				if (ch == CHAR_CR) begin
					term_col = 0;
				end else if (ch == CHAR_LF) begin
					feed_line();
				end else if (ch >= PRINT_LO && ch <= PRINT_HI) begin
					// A full line wraps before the character is stored.
					if (term_col >= COLS - 1) begin
						feed_line();
					end
					p = phys_of(term_row);
					term_cell[p * COLS + term_col] = ch[CHAR_W-1:0];
					term_col++;
					term_len[p] = term_col;
				end
			end
			KIND_READ: begin
				if (int'(row) < ROWS) begin
					p = phys_of(int'(row));
					if (int'(col) < term_len[p] && int'(col) < COLS) begin
						ans.ch = term_cell[p * COLS + int'(col)];
					end
				end
			end
			KIND_CLEAR: begin
				wipe_screen();
			end
			default: begin
			end
		endcase
		ans.row = RROW_W'(term_row);
		ans.col = RCOL_W'(term_col);
		return ans;
	endfunction

	// Records each accepted word and checks each accepted result word.
	always @(posedge clk) begin : monitor
		screen_answer_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				due_answers.push_back(emulate_terminal(kind_t'(kind), char_in, read_row,
						read_col));
			end
			if (out_valid && !out_stall) begin
				if (due_answers.size() == 0) begin
					$error("result word with none outstanding: read_char %0d, row %0d, col %0d",
							read_char, cursor_row, cursor_col);
					errors++;
				end else begin
					want = due_answers.pop_front();
					answers_checked++;
					if (want.ch != '0) begin
						chars_read++;
					end
					if (read_char !== want.ch) begin
						$error("read_char: expected %0d, actual %0d", want.ch, read_char);
						errors++;
					end
					if (cursor_row !== want.row) begin
						$error("cursor_row: expected %0d, actual %0d", want.row, cursor_row);
						errors++;
					end
					if (cursor_col !== want.col) begin
						$error("cursor_col: expected %0d, actual %0d", want.col, cursor_col);
						errors++;
					end
				end
			end
		end
	end

	// Receiving side: random stalls, or a long hold when one is requested.
	initial begin : receiver
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= rx_jitter && ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// Offers one word from a falling edge and returns once it has been taken.
	task automatic send_word(input kind_t op, input logic [BYTE_W-1:0] ch,
			input logic [RROW_W-1:0] row, input logic [RCOL_W-1:0] col);
		while (tx_jitter && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind     <= op;
		char_in  <= ch;
		read_row <= row;
		read_col <= col;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		@(negedge clk);
		words_sent++;
	endtask

	// The unused fields carry random bits so that every bit toggles.
	task automatic send_byte(input logic [BYTE_W-1:0] ch);
		send_word(KIND_BYTE, ch, RROW_W'($urandom), RCOL_W'($urandom));
	endtask

	task automatic send_read(input int row, input int col);
		send_word(KIND_READ, BYTE_W'($urandom), RROW_W'(row), RCOL_W'(col));
	endtask

	function automatic logic [BYTE_W-1:0] any_printable();
		return BYTE_W'($urandom_range(int'(PRINT_LO), int'(PRINT_HI)));
	endfunction

	// Mostly text and reads of written cells, with some noise mixed in.
	task automatic send_mixed_word();
		int pick;
		int sub;
		int row;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			sub = $urandom_range(0, 99);
			if (sub < 72) begin
				send_byte(any_printable());
			end else if (sub < 82) begin
				send_byte(CHAR_LF);
			end else if (sub < 88) begin
				send_byte(CHAR_CR);
			end else begin
				send_byte(BYTE_W'($urandom));
			end
		end else if (pick < 94) begin
			row = $urandom_range(0, ROWS - 1);
			if ($urandom_range(0, 1) == 1) begin
				send_read(row, $urandom_range(0, visible_len(row)));
			end else begin
				send_read(row, $urandom_range(0, COLS - 1));
			end
		end else if (pick < 95) begin
			send_word(KIND_CLEAR, BYTE_W'($urandom), RROW_W'($urandom), RCOL_W'($urandom));
		end else begin
			send_word(KIND_NONE, BYTE_W'($urandom), RROW_W'($urandom), RCOL_W'($urandom));
		end
	endtask

	// Field extremes, ignored bytes, the unused kind, reads, carriage return, line feed and clear.
	task automatic test_directed_edges();
		send_read(0, 0);
		send_word(KIND_NONE, '1, '1, '1);
		send_byte(PRINT_LO);
		send_byte(PRINT_HI);
		send_byte('0);
		send_byte('1);
		send_byte(PRINT_HI + 1'b1);
		send_byte(PRINT_LO - 1'b1);
		send_byte(CHAR_LF - 1'b1);
		send_byte(CHAR_LF + 1'b1);
		send_byte(CHAR_CR - 1'b1);
		send_byte(CHAR_CR + 1'b1);
		send_read(0, 0);
		send_read(0, 1);
		send_read(0, 2);
		// A carriage return then one character shortens the visible line.
		send_byte(CHAR_CR);
		send_byte(any_printable());
		send_read(0, 1);
		send_byte(CHAR_LF);
		send_read(1, 0);
		send_read(ROWS - 1, COLS - 1);
		send_word(KIND_CLEAR, '1, '1, '1);
		send_read(0, 0);
	endtask

	// Long lines, most long enough to wrap, with reads across the wrapped text.
	task automatic test_line_wrap();
		int n;
		repeat (5) begin
			n = $urandom_range(28, 40);
			repeat (n) begin
				send_byte(any_printable());
			end
			send_read(term_row, $urandom_range(0, COLS - 1));
			send_read($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
			if ($urandom_range(0, 1) == 1) begin
				send_byte(CHAR_LF);
			end
		end
	endtask

	// Many short lines so that the screen scrolls several times.
	task automatic test_scroll();
		int n;
		int row;
		repeat (24) begin
			n = $urandom_range(0, 8);
			repeat (n) begin
				send_byte(any_printable());
			end
			if ($urandom_range(0, 3) == 0) begin
				send_byte(CHAR_CR);
				send_byte(any_printable());
			end
			send_byte(CHAR_LF);
			row = $urandom_range(0, ROWS - 1);
			send_read(row, $urandom_range(0, visible_len(row)));
			send_read($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
		end
	endtask

	// The receiver holds off while words keep coming, so the input stalls.
	task automatic test_output_hold();
		hold_left = HOLD_CYCLES;
		repeat (40) begin
			send_mixed_word();
		end
	endtask

	task automatic test_back_to_back();
		tx_jitter = 1'b0;
		rx_jitter = 1'b0;
		repeat (150) begin
			send_mixed_word();
		end
		tx_jitter = 1'b1;
		rx_jitter = 1'b1;
	endtask

	task automatic test_random_mix();
		repeat (350) begin
			send_mixed_word();
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		kind     = '0;
		char_in  = '0;
		read_row = '0;
		read_col = '0;
		wipe_screen();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_edges();
		test_line_wrap();
		test_scroll();
		test_output_hold();
		test_back_to_back();
		test_random_mix();

		// Let every outstanding result word arrive, then drain before the summary.
		in_valid <= 1'b0;
		while (due_answers.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d words: text with wraps, %0d scrolls, reads, clears and noise.",
				words_sent, scrolls);
		$display("Checked %0d result words, %0d reads found a stored character, %0d mismatches.",
				answers_checked, chars_read, errors);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
